@@ hdl/mfns_pkg.sv @@
// ----------------------------------------------------------------------------
// mfns_pkg
// Widths, register indexes and reset values for the mixed feedback neuron.
// ----------------------------------------------------------------------------
`default_nettype none

package mfns_pkg;

	localparam int GAIN_W     = 21;   // gains and offsets, signed
	localparam int RATE_W     = 25;   // filter rates, unsigned Q1.24
	localparam int RATE_FRAC  = 24;
	localparam int DRIVE_W    = 22;   // input current, signed
	localparam int OUT_W      = 32;   // every result field but the flag
	localparam int TERM_W     = 22;   // one feedback current
	localparam int SUM_W      = 24;   // sum of four currents
	localparam int VDIFF_W    = 26;   // drive minus sum, before clamping
	localparam int MUL_W      = 26;   // shared multiplier operands
	localparam int PROD_W     = 2 * MUL_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 168;

	localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << RATE_FRAC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_FAST_NEG   = 3'd0,
		REG_GAIN_SLOW_POS   = 3'd1,
		REG_GAIN_SLOW_NEG   = 3'd2,
		REG_GAIN_ULTRA_POS  = 3'd3,
		REG_OFFSET_SLOW_NEG = 3'd4,
		REG_OFFSET_ULTRA    = 3'd5,
		REG_RATE_SLOW       = 3'd6,
		REG_RATE_ULTRA      = 3'd7
	} cfg_reg_t;

	localparam logic signed [GAIN_W-1:0] RST_GAIN_FAST_NEG   = -21'sd196608;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_SLOW_POS   = 21'sd196608;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_SLOW_NEG   = -21'sd131072;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_ULTRA_POS  = 21'sd131072;
	localparam logic signed [GAIN_W-1:0] RST_OFFSET_SLOW_NEG = -21'sd131072;
	localparam logic signed [GAIN_W-1:0] RST_OFFSET_ULTRA    = -21'sd131072;
	localparam logic [RATE_W-1:0]        RST_RATE_SLOW       = 25'd335544;
	localparam logic [RATE_W-1:0]        RST_RATE_ULTRA      = 25'd6711;

endpackage

`default_nettype wire

@@ hdl/mixed_feedback_neuron_step_top.sv @@
// ----------------------------------------------------------------------------
// mixed_feedback_neuron_step_top
// One neuron time step per input item: filters, four PWL currents, membrane.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one drive current per item (one time step). m_axis returns
//   one result item per step: new membrane voltage, total feedback current,
//   the three updated filter voltages and a saturation flag.
//   The cfg port writes the eight gain, offset and rate registers; write only
//   while no step is in flight.
// Timing:
//   All products go through one shared 26x26 signed multiplier with a
//   registered output, eight products per step (each filter rate product is
//   split at bit 24 into an unsigned low part and a signed high part). An
//   accepted item runs the sequencer steps, then the membrane update; a new
//   item is taken only once the block is back in idle after the result is
//   registered, so steps never overlap.
// Reset and stall:
//   Reset loads the register defaults, membrane -1.0 and filters 0.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver still holds it when the next step finishes,
//   the sequencer holds in its final cycle until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_feedback_neuron_step_top
	import mfns_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // drive_current[21:0], zero pad
	// result items
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// membrane_out[31:0], current_total[63:32], fast_out[95:64],
	// slow_out[127:96], ultraslow_out[159:128], clipped[160], zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int DW = DATA_WIDTH;
	localparam int CW = ((DW > VDIFF_W) ? DW : VDIFF_W) + 1;

	localparam logic signed [DW:0] FIX_ONE =
		{{(DW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [DW:0] FIX_MINUS_ONE = -FIX_ONE;
	localparam logic signed [CW-1:0] DMAX = (CW'(1) << (DW - 1)) - CW'(1);
	localparam logic signed [CW-1:0] DMIN = -DMAX - CW'(1);
	localparam logic signed [DW-1:0] MEM_RESET =
		{{(DW-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		SP_SLOW_LO   = 4'd0,
		SP_SLOW_HI   = 4'd1,
		SP_ULTRA_LO  = 4'd2,
		SP_ULTRA_HI  = 4'd3,
		SP_FAST      = 4'd4,
		SP_SLOW_POS  = 4'd5,
		SP_SLOW_NEG  = 4'd6,
		SP_ULTRA_POS = 4'd7,
		SP_LAST      = 4'd8
	} step_t;

	function automatic logic [OUT_W-1:0] out_proj(input logic signed [DW-1:0] x);
		logic [63:0] w;
		w = {{(64-DW){x[DW-1]}}, x};
		return w[OUT_W-1:0];
	endfunction

	// configuration registers
	logic signed [GAIN_W-1:0] gain_fn_q, gain_sp_q, gain_sn_q, gain_up_q;
	logic signed [GAIN_W-1:0] off_sn_q, off_up_q;
	logic [RATE_W-1:0]        rate_s_q, rate_u_q;

	// neuron state
	logic signed [DW-1:0] membrane_q, fast_q, slow_q, ultra_q;

	// sequencer and datapath
	state_t                    state_q;
	step_t                     step_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [RATE_FRAC-1:0]      acc_q;
	logic                      below_q, above_q;
	logic signed [GAIN_W-1:0]  gain_sel_q;
	logic signed [SUM_W-1:0]   sum_q;

	// output register
	logic                      m_tvalid_q;
	logic [OUT_W-1:0]          o_mem_q, o_cur_q, o_fast_q, o_slow_q, o_ultra_q;
	logic                      o_clip_q;

	logic [RATE_W-1:0] cfg_rate;

	always_comb begin
		cfg_rate = (cfg_data > RATE_ONE) ? RATE_ONE : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_fn_q <= RST_GAIN_FAST_NEG;
			gain_sp_q <= RST_GAIN_SLOW_POS;
			gain_sn_q <= RST_GAIN_SLOW_NEG;
			gain_up_q <= RST_GAIN_ULTRA_POS;
			off_sn_q  <= RST_OFFSET_SLOW_NEG;
			off_up_q  <= RST_OFFSET_ULTRA;
			rate_s_q  <= RST_RATE_SLOW;
			rate_u_q  <= RST_RATE_ULTRA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_FAST_NEG:   gain_fn_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_SLOW_POS:   gain_sp_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_SLOW_NEG:   gain_sn_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_ULTRA_POS:  gain_up_q <= cfg_data[GAIN_W-1:0];
				REG_OFFSET_SLOW_NEG: off_sn_q  <= cfg_data[GAIN_W-1:0];
				REG_OFFSET_ULTRA:    off_up_q  <= cfg_data[GAIN_W-1:0];
				REG_RATE_SLOW:       rate_s_q  <= cfg_rate;
				REG_RATE_ULTRA:      rate_u_q  <= cfg_rate;
				default:             ;
			endcase
		end
	end

	// operand selection for the shared multiplier
	logic signed [DW:0]       d_rate;     // membrane minus filter
	logic signed [DW:0]       pwl_v, pwl_off, pwl_diff;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic                     is_pwl;
	logic signed [GAIN_W-1:0] gain_sel;
	logic [RATE_W-1:0]        rate_sel;

	always_comb begin
		d_rate   = {membrane_q[DW-1], membrane_q} - {slow_q[DW-1], slow_q};
		rate_sel = rate_s_q;
		pwl_v    = {fast_q[DW-1], fast_q};
		pwl_off  = '0;
		gain_sel = gain_fn_q;
		is_pwl   = 1'b0;
		unique case (step_q) inside
			SP_SLOW_LO, SP_SLOW_HI: begin
				d_rate   = {membrane_q[DW-1], membrane_q} - {slow_q[DW-1], slow_q};
				rate_sel = rate_s_q;
			end
			SP_ULTRA_LO, SP_ULTRA_HI: begin
				d_rate   = {membrane_q[DW-1], membrane_q} - {ultra_q[DW-1], ultra_q};
				rate_sel = rate_u_q;
			end
			SP_FAST: begin
				is_pwl = 1'b1;
			end
			SP_SLOW_POS: begin
				pwl_v    = {slow_q[DW-1], slow_q};
				gain_sel = gain_sp_q;
				is_pwl   = 1'b1;
			end
			SP_SLOW_NEG: begin
				pwl_v    = {slow_q[DW-1], slow_q};
				pwl_off  = {{(DW+1-GAIN_W){off_sn_q[GAIN_W-1]}}, off_sn_q};
				gain_sel = gain_sn_q;
				is_pwl   = 1'b1;
			end
			SP_ULTRA_POS: begin
				pwl_v    = {ultra_q[DW-1], ultra_q};
				pwl_off  = {{(DW+1-GAIN_W){off_up_q[GAIN_W-1]}}, off_up_q};
				gain_sel = gain_up_q;
				is_pwl   = 1'b1;
			end
			default: ;
		endcase
		pwl_diff = pwl_v - pwl_off;

		// d = hi * 2^24 + lo with lo unsigned, so floor(d*r/2^24) splits exactly
		if (is_pwl) begin
			mul_a = pwl_diff[MUL_W-1:0];
			mul_b = {{(MUL_W-GAIN_W){gain_sel[GAIN_W-1]}}, gain_sel};
		end else if (step_q == SP_SLOW_LO || step_q == SP_ULTRA_LO) begin
			mul_a = {{(MUL_W-RATE_FRAC){1'b0}}, d_rate[RATE_FRAC-1:0]};
			mul_b = {{(MUL_W-RATE_W){1'b0}}, rate_sel};
		end else if (step_q == SP_SLOW_HI || step_q == SP_ULTRA_HI) begin
			mul_a = MUL_W'(signed'(d_rate[DW:RATE_FRAC]));
			mul_b = {{(MUL_W-RATE_W){1'b0}}, rate_sel};
		end else begin
			mul_a = '0;
			mul_b = '0;
		end
	end

	// result of the product issued in the previous cycle
	logic signed [PROD_W-1:0] filt_ext, filt_new;
	logic signed [PROD_W-1:0] lin_shift;
	logic signed [TERM_W-1:0] gain_ext, term;
	logic signed [VDIFF_W-1:0] v_diff;
	logic signed [CW-1:0]      v_wide;
	logic signed [DW-1:0]      mem_new;
	logic                      clip;

	always_comb begin
		filt_ext = (step_q == SP_SLOW_LO || step_q == SP_SLOW_HI || step_q == SP_ULTRA_LO)
			? {{(PROD_W-DW){slow_q[DW-1]}}, slow_q}
			: {{(PROD_W-DW){ultra_q[DW-1]}}, ultra_q};
		filt_new = filt_ext + prod_q + {{(PROD_W-RATE_FRAC){1'b0}}, acc_q};

		lin_shift = prod_q >>> FRAC_BITS;
		gain_ext  = {{(TERM_W-GAIN_W){gain_sel_q[GAIN_W-1]}}, gain_sel_q};
		if (below_q) begin
			term = -gain_ext;
		end else if (above_q) begin
			term = gain_ext;
		end else begin
			term = lin_shift[TERM_W-1:0];
		end

		v_diff = {{(VDIFF_W-DRIVE_W){drive_q[DRIVE_W-1]}}, drive_q}
			- {{(VDIFF_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
		v_wide = {{(CW-VDIFF_W){v_diff[VDIFF_W-1]}}, v_diff};
		if (v_wide > DMAX) begin
			mem_new = DMAX[DW-1:0];
			clip    = 1'b1;
		end else if (v_wide < DMIN) begin
			mem_new = DMIN[DW-1:0];
			clip    = 1'b1;
		end else begin
			mem_new = v_wide[DW-1:0];
			clip    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q     <= mul_a * mul_b;
		below_q    <= pwl_diff < FIX_MINUS_ONE;
		above_q    <= pwl_diff > FIX_ONE;
		gain_sel_q <= gain_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= SP_SLOW_LO;
			membrane_q <= MEM_RESET;
			fast_q     <= '0;
			slow_q     <= '0;
			ultra_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// in the final cycle the handover below decides the valid flag
			if (m_tvalid_q && m_axis_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						drive_q <= s_axis_tdata[DRIVE_W-1:0];
						step_q  <= SP_SLOW_LO;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					unique case (step_q) inside
						SP_SLOW_LO:  fast_q <= membrane_q;
						SP_SLOW_HI, SP_ULTRA_HI: acc_q <= prod_q[2*RATE_FRAC-1:RATE_FRAC];
						SP_ULTRA_LO: slow_q <= filt_new[DW-1:0];
						SP_FAST:     ultra_q <= filt_new[DW-1:0];
						SP_SLOW_POS: sum_q <= {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
						default:     sum_q <= sum_q + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
					endcase
					if (step_q == SP_LAST) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_t'(step_q + 4'd1);
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_axis_tready) begin
						membrane_q <= mem_new;
						o_mem_q    <= out_proj(mem_new);
						o_cur_q    <= {{(OUT_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
						o_fast_q   <= out_proj(fast_q);
						o_slow_q   <= out_proj(slow_q);
						o_ultra_q  <= out_proj(ultra_q);
						o_clip_q   <= clip;
						m_tvalid_q <= 1'b1;
						step_q     <= SP_SLOW_LO;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {7'b0, o_clip_q, o_ultra_q, o_slow_q, o_fast_q, o_cur_q, o_mem_q};

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_RUN && step_q == SP_SLOW_LO))
		else $error("accepted item did not start the sequencer");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final cycle");

	a_clip_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && o_clip_q) |->
			(membrane_q == DMAX[DW-1:0] || membrane_q == DMIN[DW-1:0]))
		else $error("clipped flag without a saturated membrane");

	a_rate_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_s_q <= RATE_ONE) && (rate_u_q <= RATE_ONE))
		else $error("filter rate above one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_axis_tready) |=> $stable(o_mem_q) && $stable(o_cur_q))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_mixed_feedback_neuron_step_top.sv @@
// ----------------------------------------------------------------------------
// tb_mixed_feedback_neuron_step_top
// Self-checking bench for the mixed feedback neuron step block.
// A queue of drive currents feeds the input stream with random gaps. The
// neuron state is tracked in the bench and one result item is predicted
// per accepted step. Returned items are checked field by field while the
// receiver stalls at random. Phases: reset defaults, filter boundary hits
// with unit rates, extreme register settings, then random settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mixed_feedback_neuron_step_top
	import mfns_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC        = 16;
	localparam longint UNIT        = longint'(1) << FRAC;
	localparam longint DRIVE_MAX   = longint'(1) << 20;
	localparam longint COEFF_MAX   = longint'(1) << 19;
	localparam longint RATE_UNITY  = longint'(1) << RATE_FRAC;
	localparam longint MEMB_MAX    = 64'sd2147483647;
	localparam longint MEMB_MIN    = -64'sd2147483648;
	localparam int     CYCLE_LIMIT = 200000;

	typedef struct {
		longint membrane;
		longint fast;
		longint slow;
		longint ultra;
	} neuron_state_t;

	typedef struct {
		logic [OUT_W-1:0] membrane;
		logic [OUT_W-1:0] total;
		logic [OUT_W-1:0] fast;
		logic [OUT_W-1:0] slow;
		logic [OUT_W-1:0] ultra;
		logic             clipped;
	} step_result_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	// bench copy of the block's registers and state
	longint        cfg_shadow [8];
	neuron_state_t neuron_now;

	logic signed [DRIVE_W-1:0] drive_q [$];
	step_result_t              step_results_due [$];
	int unsigned               queued_count   = 0;
	int unsigned               accepted_count = 0;
	int unsigned               error_count    = 0;
	int unsigned               cycle_count    = 0;
	int unsigned               send_gap       = 0;
	int unsigned               recv_stall     = 0;
	bit                        item_taken     = 0;
	bit                        no_gaps        = 0;

	mixed_feedback_neuron_step_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// floor(diff * rate / 2^24); rate is already clamped to one
	function automatic longint scale_by_rate(longint diff, longint rate);
		return (diff * rate) >>> RATE_FRAC;
	endfunction

	// saturating piecewise-linear current, boundaries inside the ramp
	function automatic longint pwl_term(longint v, longint gain, longint center);
		if (v < center - UNIT)
			return -gain;
		if (v > center + UNIT)
			return gain;
		return (gain * (v - center)) >>> FRAC;
	endfunction

	function automatic step_result_t advance_neuron(inout neuron_state_t st, input longint drive);
		step_result_t res;
		longint       total;
		longint       v;
		st.fast = st.membrane;
		st.slow += scale_by_rate(st.membrane - st.slow, cfg_shadow[REG_RATE_SLOW]);
		st.ultra += scale_by_rate(st.membrane - st.ultra, cfg_shadow[REG_RATE_ULTRA]);
		total = pwl_term(st.fast, cfg_shadow[REG_GAIN_FAST_NEG], 0)
			+ pwl_term(st.slow, cfg_shadow[REG_GAIN_SLOW_POS], 0)
			+ pwl_term(st.slow, cfg_shadow[REG_GAIN_SLOW_NEG], cfg_shadow[REG_OFFSET_SLOW_NEG])
			+ pwl_term(st.ultra, cfg_shadow[REG_GAIN_ULTRA_POS], cfg_shadow[REG_OFFSET_ULTRA]);
		v = drive - total;
		res.clipped = 1'b0;
		if (v > MEMB_MAX) begin
			v = MEMB_MAX;
			res.clipped = 1'b1;
		end else if (v < MEMB_MIN) begin
			v = MEMB_MIN;
			res.clipped = 1'b1;
		end
		st.membrane = v;
		res.membrane = OUT_W'(v);
		res.total = OUT_W'(total);
		res.fast = OUT_W'(st.fast);
		res.slow = OUT_W'(st.slow);
		res.ultra = OUT_W'(st.ultra);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
		error_count++;
	endtask

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- driver
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			step_results_due.push_back(
				advance_neuron(neuron_now, longint'($signed(s_axis_tdata[DRIVE_W-1:0]))));
			accepted_count++;
			item_taken = 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || item_taken)) begin
			item_taken = 0;
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (drive_q.size() > 0) begin
				s_axis_tdata <= IN_TDATA_W'(drive_q.pop_front()) & {{IN_TDATA_W-DRIVE_W{1'b0}},
					{DRIVE_W{1'b1}}};
				s_axis_tvalid <= 1'b1;
				send_gap = no_gaps ? 0 : $urandom_range(0, 10);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			recv_stall = no_gaps ? 0 : $urandom_range(0, 10);
			if (step_results_due.size() == 0) begin
				report_mismatch("unexpected item", m_axis_tdata[31:0], 0);
			end else begin
				want = step_results_due.pop_front();
				if (m_axis_tdata[31:0] !== want.membrane)
					report_mismatch("membrane_out", m_axis_tdata[31:0], want.membrane);
				if (m_axis_tdata[63:32] !== want.total)
					report_mismatch("current_total", m_axis_tdata[63:32], want.total);
				if (m_axis_tdata[95:64] !== want.fast)
					report_mismatch("fast_out", m_axis_tdata[95:64], want.fast);
				if (m_axis_tdata[127:96] !== want.slow)
					report_mismatch("slow_out", m_axis_tdata[127:96], want.slow);
				if (m_axis_tdata[159:128] !== want.ultra)
					report_mismatch("ultraslow_out", m_axis_tdata[159:128], want.ultra);
				if (m_axis_tdata[160] !== want.clipped)
					report_mismatch("clipped", m_axis_tdata[160], want.clipped);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic queue_drive(input longint d);
		drive_q.push_back(DRIVE_W'(d));
		queued_count++;
	endtask

	task automatic wait_idle;
		while (accepted_count != queued_count || step_results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input longint value);
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx) inside
			REG_RATE_SLOW, REG_RATE_ULTRA:
				cfg_shadow[idx] = (v > RATE_ONE) ? RATE_UNITY : longint'(v);
			default:
				cfg_shadow[idx] = longint'($signed(v[GAIN_W-1:0]));
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic longint random_drive();
		case ($urandom_range(0, 9)) inside
			0: return $urandom_range(0, 1) ? DRIVE_MAX : -DRIVE_MAX;
			1, 2, 3: return longint'($urandom_range(0, 2 * DRIVE_MAX)) - DRIVE_MAX;
			default: return longint'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
		endcase
	endfunction

	// gains and offsets: mostly a few units, sometimes anywhere in range
	function automatic longint random_coeff();
		case ($urandom_range(0, 9)) inside
			0: return $urandom_range(0, 1) ? COEFF_MAX : -COEFF_MAX;
			1, 2, 3: return longint'($urandom_range(0, 2 * COEFF_MAX)) - COEFF_MAX;
			default: return longint'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
		endcase
	endfunction

	function automatic longint random_rate();
		case ($urandom_range(0, 7)) inside
			0: return 0;
			1: return RATE_UNITY;
			2: return longint'($urandom_range(RATE_UNITY + 1, 2 * RATE_UNITY - 1));
			3, 4: return longint'($urandom_range(0, RATE_UNITY));
			default: return longint'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	initial begin
		neuron_state_t ahead;
		neuron_state_t trial;
		step_result_t  probe;
		longint        d;
		longint        targets [$];
		int unsigned   n;

		cfg_shadow[REG_GAIN_FAST_NEG]   = RST_GAIN_FAST_NEG;
		cfg_shadow[REG_GAIN_SLOW_POS]   = RST_GAIN_SLOW_POS;
		cfg_shadow[REG_GAIN_SLOW_NEG]   = RST_GAIN_SLOW_NEG;
		cfg_shadow[REG_GAIN_ULTRA_POS]  = RST_GAIN_ULTRA_POS;
		cfg_shadow[REG_OFFSET_SLOW_NEG] = RST_OFFSET_SLOW_NEG;
		cfg_shadow[REG_OFFSET_ULTRA]    = RST_OFFSET_ULTRA;
		cfg_shadow[REG_RATE_SLOW]       = longint'(RST_RATE_SLOW);
		cfg_shadow[REG_RATE_ULTRA]      = longint'(RST_RATE_ULTRA);
		neuron_now = '{membrane: -UNIT, fast: 0, slow: 0, ultra: 0};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults, drive extremes
		queue_drive(-DRIVE_MAX);
		queue_drive(DRIVE_MAX);
		queue_drive(0);
		queue_drive(1);
		queue_drive(-1);
		wait_idle();

		// unit rates: every filter lands on the membrane voltage, so drives
		// are chosen to put it exactly on and next to the ramp corners
		write_reg(REG_RATE_SLOW, RATE_UNITY);
		write_reg(REG_RATE_ULTRA, 2 * RATE_UNITY - 1);   // above one acts as one
		targets = '{UNIT, UNIT + 1, UNIT - 1, -UNIT, -UNIT - 1, -UNIT + 1,
			-3 * UNIT, -3 * UNIT - 1, -2 * UNIT, 0};
		ahead = neuron_now;
		foreach (targets[i]) begin
			trial = ahead;
			probe = advance_neuron(trial, 0);
			d = targets[i] - longint'($signed(probe.membrane));
			if (d > DRIVE_MAX)
				d = DRIVE_MAX;
			else if (d < -DRIVE_MAX)
				d = -DRIVE_MAX;
			queue_drive(d);
			probe = advance_neuron(ahead, d);
		end
		queue_drive(0);
		wait_idle();

		// extreme settings, both signs
		for (int s = 0; s < 2; s++) begin
			write_reg(REG_GAIN_FAST_NEG, s ? COEFF_MAX : -COEFF_MAX);
			write_reg(REG_GAIN_SLOW_POS, s ? COEFF_MAX : -COEFF_MAX);
			write_reg(REG_GAIN_SLOW_NEG, s ? COEFF_MAX : -COEFF_MAX);
			write_reg(REG_GAIN_ULTRA_POS, s ? COEFF_MAX : -COEFF_MAX);
			write_reg(REG_OFFSET_SLOW_NEG, s ? -COEFF_MAX : COEFF_MAX);
			write_reg(REG_OFFSET_ULTRA, s ? -COEFF_MAX : COEFF_MAX);
			write_reg(REG_RATE_SLOW, s ? RATE_UNITY : 0);
			write_reg(REG_RATE_ULTRA, s ? 1 : 0);
			queue_drive(DRIVE_MAX);
			queue_drive(-DRIVE_MAX);
			queue_drive(DRIVE_MAX);
			queue_drive(0);
			wait_idle();
		end

		// random settings and drives
		for (int p = 0; p < 16; p++) begin
			for (int r = 0; r < 6; r++)
				write_reg(cfg_reg_t'(r), random_coeff());
			write_reg(REG_RATE_SLOW, random_rate());
			write_reg(REG_RATE_ULTRA, random_rate());
			no_gaps = ($urandom_range(0, 3) == 0);
			n = $urandom_range(40, 65);
			repeat (n) queue_drive(random_drive());
			wait_idle();
		end

		no_gaps = 0;
		repeat (20) @(posedge clk);
		if (step_results_due.size() != 0)
			report_mismatch("missing items", step_results_due.size(), 0);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
